// ===== hdl/jsp_pkg.sv =====
package jsp_pkg;

    // byte classes reported on the result channel
    localparam logic [3:0] CLS_LENHI   = 4'd0;
    localparam logic [3:0] CLS_LENLO   = 4'd1;
    localparam logic [3:0] CLS_COUNT   = 4'd2;
    localparam logic [3:0] CLS_COMPID  = 4'd3;
    localparam logic [3:0] CLS_TABLES  = 4'd4;
    localparam logic [3:0] CLS_SSTART  = 4'd5;
    localparam logic [3:0] CLS_SEND    = 4'd6;
    localparam logic [3:0] CLS_APPROX  = 4'd7;
    localparam logic [3:0] CLS_EXTRA   = 4'd8;
    localparam logic [3:0] CLS_DATA    = 4'd9;
    localparam logic [3:0] CLS_FFPEND  = 4'd10;
    localparam logic [3:0] CLS_STUFFED = 4'd11;
    localparam logic [3:0] CLS_RESTART = 4'd12;
    localparam logic [3:0] CLS_END     = 4'd13;

    // parser phases
    localparam logic [3:0] PH_LENHI  = 4'd0;
    localparam logic [3:0] PH_LENLO  = 4'd1;
    localparam logic [3:0] PH_COUNT  = 4'd2;
    localparam logic [3:0] PH_COMP   = 4'd3;
    localparam logic [3:0] PH_SSTART = 4'd4;
    localparam logic [3:0] PH_SEND   = 4'd5;
    localparam logic [3:0] PH_APPROX = 4'd6;
    localparam logic [3:0] PH_EXTRA  = 4'd7;
    localparam logic [3:0] PH_DATA   = 4'd8;
    localparam logic [3:0] PH_FFPEND = 4'd9;

    localparam logic [7:0] BYTE_FF       = 8'hFF;
    localparam logic [7:0] BYTE_00       = 8'h00;
    localparam logic [7:0] BYTE_RST_LO   = 8'hD0;
    localparam logic [7:0] BYTE_RST_HI   = 8'hD7;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;
    localparam logic [15:0] SCAN_MAX     = 16'hFFFF;
    localparam logic [15:0] HDR_FIXED    = 16'd6;

    typedef struct packed {
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  byte_class;
        logic [15:0] field_value;
        logic [3:0]  dc_table;
        logic [3:0]  ac_table;
        logic [2:0]  restart_index;
        logic [31:0] segment_length;
        logic [15:0] scan_number;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  length_high_byte;
        logic [15:0] header_length;
        logic [7:0]  components_left;
        logic        second_of_pair;
        logic [15:0] extra_left;
        logic [15:0] scans_seen;
    } t_parse_state;

endpackage

// ===== hdl/jsp_stream_if.sv =====
interface jsp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/jsp_step.sv =====
module jsp_step #(
    parameter int COUNT_WIDTH = 32
) (
    input  jsp_pkg::t_parse_state     i_state,
    input  logic [COUNT_WIDTH-1:0]    i_count,
    input  logic [7:0]                i_byte,
    output jsp_pkg::t_parse_state     o_state,
    output logic [COUNT_WIDTH-1:0]    o_count,
    output jsp_pkg::t_out_item        o_result
);
    import jsp_pkg::*;

    logic [15:0]          w_used;
    logic [15:0]          w_extra;
    logic [15:0]          w_full_len;
    logic [7:0]           w_comp_dec;
    logic [15:0]          w_extra_dec;
    logic [1:0]           w_inc;
    logic [COUNT_WIDTH:0] w_sum;
    logic [COUNT_WIDTH-1:0] w_count_inc;
    logic                 w_clear;
    logic                 w_is_restart;

    assign w_full_len   = {i_state.length_high_byte, i_byte};
    assign w_used       = 16'({i_byte, 1'b0}) + HDR_FIXED;
    assign w_extra      = (w_used < i_state.header_length) ?
                          (i_state.header_length - w_used) : 16'd0;
    assign w_comp_dec   = i_state.components_left - 8'd1;
    assign w_extra_dec  = i_state.extra_left - 16'd1;
    assign w_is_restart = (i_byte >= BYTE_RST_LO) && (i_byte <= BYTE_RST_HI);

    // saturating entropy byte counter
    assign w_sum = {1'b0, i_count} + (COUNT_WIDTH+1)'(w_inc);
    assign w_count_inc = w_sum[COUNT_WIDTH] ? '1 : w_sum[COUNT_WIDTH-1:0];
    assign o_count = w_clear ? '0 : w_count_inc;

    always_comb begin
        o_state  = i_state;
        w_inc    = 2'd0;
        w_clear  = 1'b0;
        o_result = '0;
        o_result.field_value = 16'(i_byte);

        unique case (i_state.phase)
            PH_LENLO: begin
                o_result.byte_class  = CLS_LENLO;
                o_result.field_value = w_full_len;
                o_state.header_length = w_full_len;
                o_state.phase = PH_COUNT;
            end
            PH_COUNT: begin
                o_result.byte_class = CLS_COUNT;
                o_state.components_left = i_byte;
                o_state.second_of_pair  = 1'b0;
                o_state.extra_left      = w_extra;
                o_state.phase = (i_byte == BYTE_00) ? PH_SSTART : PH_COMP;
            end
            PH_COMP: begin
                if (!i_state.second_of_pair) begin
                    o_result.byte_class    = CLS_COMPID;
                    o_state.second_of_pair = 1'b1;
                end else begin
                    o_result.byte_class    = CLS_TABLES;
                    o_result.dc_table      = i_byte[7:4];
                    o_result.ac_table      = 4'(i_byte & NIBBLE_MASK);
                    o_state.second_of_pair = 1'b0;
                    o_state.components_left = w_comp_dec;
                    if (w_comp_dec == 8'd0) begin
                        o_state.phase = PH_SSTART;
                    end
                end
            end
            PH_SSTART: begin
                o_result.byte_class = CLS_SSTART;
                o_state.phase = PH_SEND;
            end
            PH_SEND: begin
                o_result.byte_class = CLS_SEND;
                o_state.phase = PH_APPROX;
            end
            PH_APPROX: begin
                o_result.byte_class = CLS_APPROX;
                w_clear = 1'b1;
                o_state.phase = (i_state.extra_left != 16'd0) ? PH_EXTRA : PH_DATA;
            end
            PH_EXTRA: begin
                o_result.byte_class = CLS_EXTRA;
                o_state.extra_left  = w_extra_dec;
                if (w_extra_dec == 16'd0) begin
                    o_state.phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_byte == BYTE_FF) begin
                    o_result.byte_class = CLS_FFPEND;
                    o_state.phase = PH_FFPEND;
                end else begin
                    o_result.byte_class = CLS_DATA;
                    w_inc = 2'd1;
                end
            end
            PH_FFPEND: begin
                if (i_byte == BYTE_00) begin
                    // stuffed pair counts both bytes
                    o_result.byte_class = CLS_STUFFED;
                    w_inc = 2'd2;
                    o_state.phase = PH_DATA;
                end else if (w_is_restart) begin
                    o_result.byte_class     = CLS_RESTART;
                    o_result.restart_index  = i_byte[2:0];
                    o_result.segment_length = 32'(i_count);
                    w_clear = 1'b1;
                    o_state.phase = PH_DATA;
                end else begin
                    o_result.byte_class     = CLS_END;
                    o_result.segment_length = 32'(i_count);
                    w_clear = 1'b1;
                    o_state.phase = PH_LENHI;
                end
            end
            default: begin
                // awaiting length high byte: a new scan begins
                o_result.byte_class = CLS_LENHI;
                o_state.length_high_byte = i_byte;
                if (i_state.scans_seen != SCAN_MAX) begin
                    o_state.scans_seen = i_state.scans_seen + 16'd1;
                end
                o_state.phase = PH_LENLO;
            end
        endcase

        o_result.scan_number = o_state.scans_seen;
    end

endmodule

// ===== hdl/jpeg_scan_header_and_marker_parser_core.sv =====
// jpeg scan header and marker parser
//
// i_in carries the bytes that follow a start-of-scan marker, one per
// transfer. o_out carries one classified result per input byte, in order:
// byte class, decoded value, table nibbles, restart index, entropy segment
// length on restart and end markers, and the running scan number.
//
// a byte is held in an input register, classified against the parser state
// in one pass of logic, and lands in the output register together with the
// state update; a result thus passes the input register and then the output
// register before it is offered. throughput is one byte per cycle while the
// receiver takes results, as the state update is registered with the result.
//
// when the receiver stalls the result waits in the output register and one
// more byte can still be taken into the input register; after that i_in
// ready drops until the result is taken.
//
// synchronous reset clears both register stages and puts the parser back in
// the state of awaiting a length high byte with all counters at zero.
module jpeg_scan_header_and_marker_parser_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jsp_stream_if.sink    i_in,
    jsp_stream_if.source  o_out
);
    import jsp_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid;
    t_out_item              r_out;
    t_parse_state           r_state;
    logic [COUNT_WIDTH-1:0] r_count;

    t_parse_state           n_state;
    logic [COUNT_WIDTH-1:0] n_count;
    t_out_item              n_out;
    logic                   w_adv;

    assign w_adv         = !r_out_valid || o_out.ready;
    assign i_in.ready    = !r_in_valid || w_adv;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    jsp_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_state  (r_state),
        .i_count  (r_count),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_count  (n_count),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_count     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                    r_count <= n_count;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.payload.data_byte;
        end
        if (w_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import jsp_pkg::*;

    localparam int          COUNT_W     = 32;
    localparam logic [63:0] ENTROPY_MAX = (64'd1 << COUNT_W) - 64'd1;

    typedef struct {
        logic [7:0] data;
        bit         known;
        t_out_item  want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    jsp_stream_if #(.t_payload(t_in_item))  in_stream ();
    jsp_stream_if #(.t_payload(t_out_item)) out_stream ();

    jpeg_scan_header_and_marker_parser_core #(
        .COUNT_WIDTH(COUNT_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_stream),
        .o_out   (out_stream)
    );

    // parser state as the block should hold it
    logic [3:0]  parse_phase;
    logic [7:0]  len_high;
    logic [15:0] hdr_len;
    logic [7:0]  comps_left;
    logic        pair_second;
    logic [15:0] extra_left;
    logic [63:0] entropy_cnt;
    logic [15:0] scans_begun;

    t_out_item pending_results[$];
    t_row      directed_rows[$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  burst_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL jpeg_scan_header_and_marker_parser_core");
        $finish;
    end

    function automatic void count_entropy(input logic [63:0] n);
        if (entropy_cnt > ENTROPY_MAX - n) begin
            entropy_cnt = ENTROPY_MAX;
        end else begin
            entropy_cnt = entropy_cnt + n;
        end
    endfunction

    function automatic t_out_item parse_byte(input logic [7:0] b);
        t_out_item   r;
        logic [16:0] used;
        r = '0;
        r.field_value = {8'h00, b};
        case (parse_phase)
            PH_LENLO: begin
                r.byte_class  = CLS_LENLO;
                hdr_len       = {len_high, b};
                r.field_value = hdr_len;
                parse_phase   = PH_COUNT;
            end
            PH_COUNT: begin
                r.byte_class = CLS_COUNT;
                comps_left   = b;
                pair_second  = 1'b0;
                used         = {8'h00, b, 1'b0} + {1'b0, HDR_FIXED};
                extra_left   = (used < {1'b0, hdr_len}) ? hdr_len - used[15:0] : 16'd0;
                parse_phase  = (b == BYTE_00) ? PH_SSTART : PH_COMP;
            end
            PH_COMP: begin
                if (!pair_second) begin
                    r.byte_class = CLS_COMPID;
                    pair_second  = 1'b1;
                end else begin
                    r.byte_class = CLS_TABLES;
                    r.dc_table   = b[7:4];
                    r.ac_table   = b[3:0];
                    pair_second  = 1'b0;
                    comps_left   = comps_left - 8'd1;
                    if (comps_left == 8'd0) begin
                        parse_phase = PH_SSTART;
                    end
                end
            end
            PH_SSTART: begin
                r.byte_class = CLS_SSTART;
                parse_phase  = PH_SEND;
            end
            PH_SEND: begin
                r.byte_class = CLS_SEND;
                parse_phase  = PH_APPROX;
            end
            PH_APPROX: begin
                r.byte_class = CLS_APPROX;
                entropy_cnt  = '0;
                parse_phase  = (extra_left != 16'd0) ? PH_EXTRA : PH_DATA;
            end
            PH_EXTRA: begin
                r.byte_class = CLS_EXTRA;
                extra_left   = extra_left - 16'd1;
                if (extra_left == 16'd0) begin
                    parse_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (b == BYTE_FF) begin
                    r.byte_class = CLS_FFPEND;
                    parse_phase  = PH_FFPEND;
                end else begin
                    r.byte_class = CLS_DATA;
                    count_entropy(64'd1);
                end
            end
            PH_FFPEND: begin
                if (b == BYTE_00) begin
                    r.byte_class = CLS_STUFFED;
                    count_entropy(64'd2);
                    parse_phase  = PH_DATA;
                end else if (b >= BYTE_RST_LO && b <= BYTE_RST_HI) begin
                    r.byte_class     = CLS_RESTART;
                    r.restart_index  = b[2:0];
                    r.segment_length = entropy_cnt[31:0];
                    entropy_cnt      = '0;
                    parse_phase      = PH_DATA;
                end else begin
                    // anything else, a second 0xff too, closes the scan
                    r.byte_class     = CLS_END;
                    r.segment_length = entropy_cnt[31:0];
                    entropy_cnt      = '0;
                    parse_phase      = PH_LENHI;
                end
            end
            default: begin
                r.byte_class = CLS_LENHI;
                len_high     = b;
                if (scans_begun != SCAN_MAX) begin
                    scans_begun = scans_begun + 16'd1;
                end
                parse_phase  = PH_LENLO;
            end
        endcase
        r.scan_number = scans_begun;
        return r;
    endfunction

    // mostly well-formed scans with random content, steered by the parser phase
    function automatic logic [7:0] pick_stream_byte();
        int         roll;
        logic [7:0] b;
        roll = $urandom_range(0, 99);
        b    = 8'($urandom_range(0, 255));
        case (parse_phase)
            PH_LENHI: begin
                b = (roll < 92) ? 8'h00 : 8'h01;
            end
            PH_LENLO: begin
                if (roll < 50) begin
                    b = 8'($urandom_range(0, 20));
                end
            end
            PH_COUNT: begin
                if (roll < 10) begin
                    b = BYTE_00;
                end else if (roll < 96) begin
                    b = 8'($urandom_range(1, 4));
                end
            end
            PH_DATA: begin
                b = (roll < 8) ? BYTE_FF : 8'($urandom_range(0, 254));
            end
            PH_FFPEND: begin
                if (roll < 35) begin
                    b = BYTE_00;
                end else if (roll < 70) begin
                    b = BYTE_RST_LO + 8'($urandom_range(0, 7));
                end else if (roll < 80) begin
                    b = BYTE_FF;
                end
            end
            default: begin
            end
        endcase
        return b;
    endfunction

    task automatic row_free(input logic [7:0] b);
        t_row r;
        r.data  = b;
        r.known = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endtask

    task automatic row_known(input logic [7:0] b, input logic [3:0] cls,
                             input logic [15:0] val, input logic [3:0] dc,
                             input logic [3:0] ac, input logic [2:0] rst,
                             input logic [31:0] seg, input logic [15:0] scan);
        t_row r;
        r.data  = b;
        r.known = 1'b1;
        r.want  = '{cls, val, dc, ac, rst, seg, scan};
        directed_rows.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR result %0d: %s", result_count, msg);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
        end else begin
            want = pending_results.pop_front();
            if (got.byte_class !== want.byte_class)
                report_mismatch($sformatf("byte_class %0d, want %0d",
                                          got.byte_class, want.byte_class));
            if (got.field_value !== want.field_value)
                report_mismatch($sformatf("field_value %h, want %h",
                                          got.field_value, want.field_value));
            if (got.dc_table !== want.dc_table)
                report_mismatch($sformatf("dc_table %h, want %h",
                                          got.dc_table, want.dc_table));
            if (got.ac_table !== want.ac_table)
                report_mismatch($sformatf("ac_table %h, want %h",
                                          got.ac_table, want.ac_table));
            if (got.restart_index !== want.restart_index)
                report_mismatch($sformatf("restart_index %0d, want %0d",
                                          got.restart_index, want.restart_index));
            if (got.segment_length !== want.segment_length)
                report_mismatch($sformatf("segment_length %0d, want %0d",
                                          got.segment_length, want.segment_length));
            if (got.scan_number !== want.scan_number)
                report_mismatch($sformatf("scan_number %0d, want %0d",
                                          got.scan_number, want.scan_number));
        end
        result_count++;
    endtask

    // offers one byte in the current burst and records its expected result
    task automatic offer_byte(input logic [7:0] b, input bit known, input t_out_item want);
        t_out_item r;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_stream.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        in_stream.valid             <= 1'b1;
        in_stream.payload.data_byte <= b;
        do @(posedge i_clk); while (!in_stream.ready);
        r = parse_byte(b);
        pending_results.push_back(known ? want : r);
    endtask

    // receiver: changing stall patterns plus one long hold-off
    initial begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  held;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        out_stream.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_stream.valid && out_stream.ready) begin
                check_result(out_stream.payload);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            if (!held && result_count >= 300) begin
                held      = 1'b1;
                hold_left = 100;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stream.ready <= 1'b0;
            end else if (mode == 0) begin
                out_stream.ready <= 1'b1;
            end else if (mode == 1) begin
                out_stream.ready <= 1'($urandom_range(0, 1));
            end else begin
                out_stream.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        int         counted;
        int         waited;
        logic [7:0] b;
        i_rst_n                     <= 1'b0;
        in_stream.valid             <= 1'b0;
        in_stream.payload.data_byte <= 8'h00;
        parse_phase = PH_LENHI;
        len_high    = '0;
        hdr_len     = '0;
        comps_left  = '0;
        pair_second = 1'b0;
        extra_left  = '0;
        entropy_cnt = '0;
        scans_begun = '0;

        // scan with one component, two extra header bytes, stuffing and restarts
        row_known(8'h00, CLS_LENHI, 16'h0000, 4'h0, 4'h0, 3'd0, 32'd0, 16'd1);
        row_known(8'h0A, CLS_LENLO, 16'h000A, 4'h0, 4'h0, 3'd0, 32'd0, 16'd1);
        row_known(8'h01, CLS_COUNT, 16'h0001, 4'h0, 4'h0, 3'd0, 32'd0, 16'd1);
        row_known(8'hFF, CLS_COMPID, 16'h00FF, 4'h0, 4'h0, 3'd0, 32'd0, 16'd1);
        row_known(8'hFF, CLS_TABLES, 16'h00FF, 4'hF, 4'hF, 3'd0, 32'd0, 16'd1);
        row_free(8'h00);
        row_free(8'h3F);
        row_free(8'h00);
        row_free(8'hFF);
        row_free(8'h00);
        row_free(8'h12);
        row_free(8'hFF);
        row_free(8'h00);
        row_free(8'hFF);
        row_known(8'hD7, CLS_RESTART, 16'h00D7, 4'h0, 4'h0, 3'd7, 32'd3, 16'd1);
        row_free(8'hFF);
        row_known(8'hD0, CLS_RESTART, 16'h00D0, 4'h0, 4'h0, 3'd0, 32'd0, 16'd1);
        row_free(8'hFF);
        row_known(8'hFF, CLS_END, 16'h00FF, 4'h0, 4'h0, 3'd0, 32'd0, 16'd1);
        // zero components and a length too short for any extra byte
        row_known(8'h00, CLS_LENHI, 16'h0000, 4'h0, 4'h0, 3'd0, 32'd0, 16'd2);
        row_free(8'h03);
        row_known(8'h00, CLS_COUNT, 16'h0000, 4'h0, 4'h0, 3'd0, 32'd0, 16'd2);
        row_free(8'hAA);
        row_free(8'h55);
        row_free(8'hFF);
        row_free(8'hFE);
        row_free(8'hFF);
        row_free(8'hD8);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            offer_byte(directed_rows[i].data, directed_rows[i].known, directed_rows[i].want);
        end

        counted = 0;
        while (counted < 2000) begin
            b = pick_stream_byte();
            offer_byte(b, 1'b0, '0);
            counted++;
            if (counted == 1500) begin
                in_stream.valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
                burst_left = 0;
            end
        end
        in_stream.valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never came",
                                      pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("PASS jpeg_scan_header_and_marker_parser_core");
        end else begin
            $display("FAIL jpeg_scan_header_and_marker_parser_core");
        end
        $finish;
    end

endmodule
